FILE: rtl/bspline_curve_point_evaluator_assert.svh
// Assertion macros for the B-spline curve point evaluator.
`ifndef BSPLINE_CURVE_POINT_EVALUATOR_ASSERT_SVH
`define BSPLINE_CURVE_POINT_EVALUATOR_ASSERT_SVH

// condition that holds at every edge outside reset
`define BSPL_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition that holds in the cycle after a trigger
`define BSPL_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/bspl_pkg.sv
// Shared constants, types and helper functions of the B-spline curve point evaluator.
package bspl_pkg;

  localparam int SPLINE_ORDER    = 3;
  localparam int NUM_CTRL_POINTS = 5;
  localparam int KNOT_COUNT      = SPLINE_ORDER + NUM_CTRL_POINTS;
  localparam int KNOT_IDX_W      = $clog2(KNOT_COUNT);
  localparam int CTRL_IDX_W      = $clog2(NUM_CTRL_POINTS);

  localparam int KNOT_W     = 16;
  localparam int POINT_W    = 32;
  localparam int BASIS_W    = 32;
  localparam int BASIS_FRAC = 30;
  localparam int DIFF_W     = KNOT_W + 1;
  localparam int PROD_W     = DIFF_W + BASIS_W;
  localparam int MAG_W      = PROD_W - 1;
  localparam int QUOT_W     = BASIS_W;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = QUOT_W / DIV_STEP;
  localparam int WEIGH_LAT  = DIV_STAGES + 2;

  localparam int PT_PROD_W = BASIS_W + POINT_W;
  localparam int RND_W     = PT_PROD_W - BASIS_FRAC;
  localparam int SUM_W     = RND_W + $clog2(NUM_CTRL_POINTS) + 1;

  typedef logic signed [BASIS_W-1:0] basis_t;

  localparam basis_t BASIS_ONE = BASIS_W'(64'd1 << BASIS_FRAC);
  localparam basis_t BASIS_MAX = {1'b0, {(BASIS_W-1){1'b1}}};
  localparam basis_t BASIS_MIN = {1'b1, {(BASIS_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD_KNOT  = 2'd0,
    OP_LOAD_POINT = 2'd1,
    OP_EVAL       = 2'd2,
    OP_IDLE       = 2'd3
  } op_t;

  // everything an evaluation word carries down the pipe
  typedef struct packed {
    logic [KNOT_W-1:0]                       t;
    logic                                    neg;
    logic [KNOT_COUNT-1:0][KNOT_W-1:0]       knots;
    logic [NUM_CTRL_POINTS-1:0][POINT_W-1:0] cx;
    logic [NUM_CTRL_POINTS-1:0][POINT_W-1:0] cy;
  } ctx_t;

  function automatic basis_t sat_add(basis_t a, basis_t b);
    logic signed [BASIS_W:0] s;
    s = {a[BASIS_W-1], a} + {b[BASIS_W-1], b};
    if (s[BASIS_W] != s[BASIS_W-1]) begin
      return s[BASIS_W] ? BASIS_MIN : BASIS_MAX;
    end
    return s[BASIS_W-1:0];
  endfunction

  function automatic logic signed [POINT_W-1:0] sat_point(logic signed [SUM_W-1:0] v);
    if ((&v[SUM_W-1:POINT_W-1]) || !(|v[SUM_W-1:POINT_W-1])) begin
      return v[POINT_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(POINT_W-1){1'b0}}} : {1'b0, {(POINT_W-1){1'b1}}};
  endfunction

endpackage

FILE: rtl/bspl_weigh.sv
// Pipelined weighted basis term: (diff * basis) / den, truncated and saturated.
module bspl_weigh (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [bspl_pkg::DIFF_W-1:0]  diff,
  input  logic signed [bspl_pkg::BASIS_W-1:0] basis,
  input  logic signed [bspl_pkg::DIFF_W-1:0]  den,
  output logic signed [bspl_pkg::BASIS_W-1:0] term
);

  localparam int PROD_W     = bspl_pkg::PROD_W;
  localparam int MAG_W      = bspl_pkg::MAG_W;
  localparam int QUOT_W     = bspl_pkg::QUOT_W;
  localparam int KNOT_W     = bspl_pkg::KNOT_W;
  localparam int DIFF_W     = bspl_pkg::DIFF_W;
  localparam int DIV_STAGES = bspl_pkg::DIV_STAGES;
  localparam int DIV_STEP   = bspl_pkg::DIV_STEP;

  logic signed [PROD_W-1:0] prod;
  logic [MAG_W-1:0]         a_mag;
  logic [KNOT_W-1:0]        a_dmag;
  logic                     a_neg;
  logic                     a_zero;

  logic [KNOT_W-1:0] d_rem  [DIV_STAGES];
  logic [QUOT_W-1:0] d_low  [DIV_STAGES];
  logic [QUOT_W-1:0] d_q    [DIV_STAGES];
  logic [KNOT_W-1:0] d_dmag [DIV_STAGES];
  logic              d_neg  [DIV_STAGES];
  logic              d_zero [DIV_STAGES];
  logic              d_ovf  [DIV_STAGES];

  logic [QUOT_W-1:0] qf;

  assign prod = diff * basis;

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag  <= prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
      a_dmag <= den[DIFF_W-1] ? KNOT_W'(-den) : KNOT_W'(den);
      a_neg  <= prod[PROD_W-1] ^ den[DIFF_W-1];
      a_zero <= (den == '0);
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [KNOT_W-1:0] rem_in;
    logic [KNOT_W-1:0] rem_c;
    logic [QUOT_W-1:0] low_in;
    logic [QUOT_W-1:0] low_c;
    logic [QUOT_W-1:0] q_in;
    logic [QUOT_W-1:0] q_c;
    logic [KNOT_W-1:0] dm_in;
    logic              neg_in;
    logic              zero_in;
    logic              ovf_in;
    logic [KNOT_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = a_mag[MAG_W-1:QUOT_W];
      assign low_in  = a_mag[QUOT_W-1:0];
      assign q_in    = '0;
      assign dm_in   = a_dmag;
      assign neg_in  = a_neg;
      assign zero_in = a_zero;
      // quotient needs more than QUOT_W bits
      assign ovf_in  = (a_mag[MAG_W-1:QUOT_W] >= a_dmag);
    end else begin : g_rest
      assign rem_in  = d_rem[k-1];
      assign low_in  = d_low[k-1];
      assign q_in    = d_q[k-1];
      assign dm_in   = d_dmag[k-1];
      assign neg_in  = d_neg[k-1];
      assign zero_in = d_zero[k-1];
      assign ovf_in  = d_ovf[k-1];
    end

    always_comb begin
      rem_c = rem_in;
      low_c = low_in;
      q_c   = q_in;
      trial = '0;
      for (int s = 0; s < DIV_STEP; s++) begin
        trial = {rem_c, low_c[QUOT_W-1]};
        low_c = {low_c[QUOT_W-2:0], 1'b0};
        if (trial >= {1'b0, dm_in}) begin
          rem_c = KNOT_W'(trial - {1'b0, dm_in});
          q_c   = {q_c[QUOT_W-2:0], 1'b1};
        end else begin
          rem_c = trial[KNOT_W-1:0];
          q_c   = {q_c[QUOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[k]  <= rem_c;
        d_low[k]  <= low_c;
        d_q[k]    <= q_c;
        d_dmag[k] <= dm_in;
        d_neg[k]  <= neg_in;
        d_zero[k] <= zero_in;
        d_ovf[k]  <= ovf_in;
      end
    end
  end

  assign qf = d_q[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_zero[DIV_STAGES-1]) begin
        term <= '0;
      end else if (!d_neg[DIV_STAGES-1]) begin
        term <= (d_ovf[DIV_STAGES-1] || qf[QUOT_W-1]) ? bspl_pkg::BASIS_MAX : $signed(qf);
      end else begin
        term <= (d_ovf[DIV_STAGES-1] || (qf[QUOT_W-1] && (|qf[QUOT_W-2:0])))
                ? bspl_pkg::BASIS_MIN : $signed(-qf);
      end
    end
  end

endmodule

FILE: rtl/bspline_curve_point_evaluator.sv
// Top level of the B-spline curve point evaluator.
// Each input word either loads a knot (Q4.12) or a control point (Q16.16) into
// small register tables, asks for the curve point at parameter t, or is idle; an
// evaluation returns one saturated Q16.16 point, loads return nothing. One word
// is taken every cycle while the output is not stalled. An evaluation word
// snapshots the tables when it is taken, then passes a capture stage,
// SPLINE_ORDER-1 recursion layers of WEIGH_LAT+1 stages each (the radix-16
// restoring divider, 4 quotient bits per stage, sets that depth), and four
// stages of point multiply, rounding, sum and saturation. Back-pressure on the
// output stalls the whole pipe.
`include "bspline_curve_point_evaluator_assert.svh"

module bspline_curve_point_evaluator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          op,
  input  logic [2:0]                          slot,
  input  logic [bspl_pkg::KNOT_W-1:0]         knot_value,
  input  logic signed [bspl_pkg::POINT_W-1:0] point_x,
  input  logic signed [bspl_pkg::POINT_W-1:0] point_y,
  input  logic [bspl_pkg::KNOT_W-1:0]         param_t,
  input  logic                                negate_x,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [bspl_pkg::POINT_W-1:0] curve_x,
  output logic signed [bspl_pkg::POINT_W-1:0] curve_y
);

  localparam int KC        = bspl_pkg::KNOT_COUNT;
  localparam int NCP       = bspl_pkg::NUM_CTRL_POINTS;
  localparam int NLAYER    = bspl_pkg::SPLINE_ORDER - 1;
  localparam int LAST      = bspl_pkg::SPLINE_ORDER - 1;
  localparam int WLAT      = bspl_pkg::WEIGH_LAT;
  localparam int KNOT_W    = bspl_pkg::KNOT_W;
  localparam int POINT_W   = bspl_pkg::POINT_W;
  localparam int DIFF_W    = bspl_pkg::DIFF_W;
  localparam int PT_PROD_W = bspl_pkg::PT_PROD_W;
  localparam int RND_W     = bspl_pkg::RND_W;
  localparam int SUM_W     = bspl_pkg::SUM_W;
  localparam logic signed [PT_PROD_W-1:0] RND_BIAS =
    PT_PROD_W'(1) << (bspl_pkg::BASIS_FRAC - 1);

  logic en;
  logic accept;

  logic [KNOT_W-1:0]  knot_tab   [KC];
  logic [POINT_W-1:0] ctrl_x_tab [NCP];
  logic [POINT_W-1:0] ctrl_y_tab [NCP];

  bspl_pkg::ctx_t   cap_ctx;
  logic             lval [bspl_pkg::SPLINE_ORDER];
  bspl_pkg::ctx_t   lctx [bspl_pkg::SPLINE_ORDER];
  bspl_pkg::basis_t lb   [bspl_pkg::SPLINE_ORDER][KC];

  logic                        p_val;
  logic                        p_neg;
  logic signed [PT_PROD_W-1:0] p_x [NCP];
  logic signed [PT_PROD_W-1:0] p_y [NCP];
  logic                        r_val;
  logic                        r_neg;
  logic signed [RND_W-1:0]     r_x [NCP];
  logic signed [RND_W-1:0]     r_y [NCP];
  logic signed [SUM_W-1:0]     sum_x;
  logic signed [SUM_W-1:0]     sum_y;
  logic                        s_val;
  logic                        s_neg;
  logic signed [SUM_W-1:0]     s_x;
  logic signed [SUM_W-1:0]     s_y;
  logic signed [SUM_W-1:0]     s_x_signed;

  assign en        = !res_valid || !res_stall;
  assign req_stall = !en;
  assign accept    = req_valid && en;

  // tables
  always_ff @(posedge clk) begin
    if (accept && op == bspl_pkg::OP_LOAD_KNOT && int'(slot) < KC) begin
      knot_tab[bspl_pkg::KNOT_IDX_W'(slot)] <= knot_value;
    end
    if (accept && op == bspl_pkg::OP_LOAD_POINT && int'(slot) < NCP) begin
      ctrl_x_tab[bspl_pkg::CTRL_IDX_W'(slot)] <= point_x;
      ctrl_y_tab[bspl_pkg::CTRL_IDX_W'(slot)] <= point_y;
    end
  end

  // capture
  always_comb begin
    cap_ctx     = '0;
    cap_ctx.t   = param_t;
    cap_ctx.neg = negate_x;
    for (int i = 0; i < KC; i++) begin
      cap_ctx.knots[i] = knot_tab[i];
    end
    for (int i = 0; i < NCP; i++) begin
      cap_ctx.cx[i] = ctrl_x_tab[i];
      cap_ctx.cy[i] = ctrl_y_tab[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lval[0] <= 1'b0;
    end else if (en) begin
      lval[0] <= req_valid && op == bspl_pkg::OP_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lctx[0] <= cap_ctx;
      for (int i = 0; i < KC - 1; i++) begin
        lb[0][i] <= (knot_tab[i] <= param_t && param_t < knot_tab[i+1])
                    ? bspl_pkg::BASIS_ONE : '0;
      end
      lb[0][KC-1] <= '0;
    end
  end

  // recursion layers, order 2 up to SPLINE_ORDER
  for (genvar l = 0; l < NLAYER; l++) begin : g_layer
    localparam int NPOS = KC - l - 2;

    bspl_pkg::basis_t ta [NPOS];
    bspl_pkg::basis_t tb [NPOS];
    bspl_pkg::ctx_t   dctx [WLAT];
    logic             dval [WLAT];

    for (genvar i = 0; i < NPOS; i++) begin : g_pos
      logic signed [DIFF_W-1:0] diff_a;
      logic signed [DIFF_W-1:0] den_a;
      logic signed [DIFF_W-1:0] diff_b;
      logic signed [DIFF_W-1:0] den_b;

      assign diff_a = $signed({1'b0, lctx[l].t}) - $signed({1'b0, lctx[l].knots[i]});
      assign den_a  = $signed({1'b0, lctx[l].knots[i+l+1]})
                    - $signed({1'b0, lctx[l].knots[i]});
      assign diff_b = $signed({1'b0, lctx[l].knots[i+l+2]}) - $signed({1'b0, lctx[l].t});
      assign den_b  = $signed({1'b0, lctx[l].knots[i+l+2]})
                    - $signed({1'b0, lctx[l].knots[i+1]});

      bspl_weigh u_weigh_a (
        .clk   (clk),
        .en    (en),
        .diff  (diff_a),
        .basis (lb[l][i]),
        .den   (den_a),
        .term  (ta[i])
      );

      bspl_weigh u_weigh_b (
        .clk   (clk),
        .en    (en),
        .diff  (diff_b),
        .basis (lb[l][i+1]),
        .den   (den_b),
        .term  (tb[i])
      );

      always_ff @(posedge clk) begin
        if (en) begin
          lb[l+1][i] <= bspl_pkg::sat_add(ta[i], tb[i]);
        end
      end
    end

    for (genvar i = NPOS; i < KC; i++) begin : g_zero
      always_ff @(posedge clk) begin
        if (en) begin
          lb[l+1][i] <= '0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int k = 0; k < WLAT; k++) begin
          dval[k] <= 1'b0;
        end
        lval[l+1] <= 1'b0;
      end else if (en) begin
        dval[0] <= lval[l];
        for (int k = 1; k < WLAT; k++) begin
          dval[k] <= dval[k-1];
        end
        lval[l+1] <= dval[WLAT-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dctx[0] <= lctx[l];
        for (int k = 1; k < WLAT; k++) begin
          dctx[k] <= dctx[k-1];
        end
        lctx[l+1] <= dctx[WLAT-1];
      end
    end
  end

  // point products, rounding, sum, output
  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int i = 0; i < NCP; i++) begin
      sum_x = sum_x + SUM_W'(r_x[i]);
      sum_y = sum_y + SUM_W'(r_y[i]);
    end
  end

  assign s_x_signed = s_neg ? -s_x : s_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_val     <= 1'b0;
      r_val     <= 1'b0;
      s_val     <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      p_val     <= lval[LAST];
      r_val     <= p_val;
      s_val     <= r_val;
      res_valid <= s_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_neg <= lctx[LAST].neg;
      for (int i = 0; i < NCP; i++) begin
        p_x[i] <= lb[LAST][i] * $signed(lctx[LAST].cx[i]);
        p_y[i] <= lb[LAST][i] * $signed(lctx[LAST].cy[i]);
      end
      r_neg <= p_neg;
      for (int i = 0; i < NCP; i++) begin
        r_x[i] <= RND_W'((p_x[i] + RND_BIAS) >>> bspl_pkg::BASIS_FRAC);
        r_y[i] <= RND_W'((p_y[i] + RND_BIAS) >>> bspl_pkg::BASIS_FRAC);
      end
      s_neg   <= r_neg;
      s_x     <= sum_x;
      s_y     <= sum_y;
      curve_x <= bspl_pkg::sat_point(s_x_signed);
      curve_y <= bspl_pkg::sat_point(s_y);
    end
  end

  `BSPL_ASSERT_NOW(a_stall_follows_output, req_stall == (res_valid && res_stall), "bad stall")
  `BSPL_ASSERT_NEXT(a_eval_enters, accept && op == bspl_pkg::OP_EVAL, lval[0], "eval lost")
  `BSPL_ASSERT_NEXT(a_load_no_entry, accept && op != bspl_pkg::OP_EVAL, !lval[0], "load entered")

endmodule
